>>> hdl/u16550rf_pkg.sv
// ----------------------------------------------------------------------------
// u16550rf_pkg
// Shared types and constants for the simplified 16550 UART register file:
// transaction payloads, action codes, register offsets and bit positions.
// ----------------------------------------------------------------------------
package u16550rf_pkg;

   localparam int unsigned RX_DEPTH_DEFAULT = 16;

   // Action codes carried by a request transaction
   localparam logic [1:0] ACT_READ  = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_LINE  = 2'd2;

   // Register offsets
   localparam logic [2:0] OFF_DATA = 3'd0;  // RBR / THR / DLL
   localparam logic [2:0] OFF_IER  = 3'd1;  // IER / DLH
   localparam logic [2:0] OFF_IIR  = 3'd2;  // IIR read, FCR write
   localparam logic [2:0] OFF_LCR  = 3'd3;
   localparam logic [2:0] OFF_MCR  = 3'd4;
   localparam logic [2:0] OFF_LSR  = 3'd5;
   localparam logic [2:0] OFF_MSR  = 3'd6;
   localparam logic [2:0] OFF_SCR  = 3'd7;

   // Bit positions
   localparam int unsigned LCR_DLAB_BIT = 7;
   localparam int unsigned MCR_DTR_BIT  = 0;
   localparam int unsigned MCR_RTS_BIT  = 1;
   localparam int unsigned MCR_OUT1_BIT = 2;
   localparam int unsigned MCR_OUT2_BIT = 3;
   localparam int unsigned MCR_LOOP_BIT = 4;
   localparam int unsigned FCR_EN_BIT   = 0;
   localparam int unsigned IER_RX_BIT   = 0;
   localparam int unsigned IER_TX_BIT   = 1;

   // Fixed read values
   localparam logic [7:0] IIR_RX        = 8'h04;
   localparam logic [7:0] IIR_TX        = 8'h02;
   localparam logic [7:0] IIR_NONE      = 8'h01;
   localparam logic [7:0] IIR_FIFO      = 8'hC0;
   localparam logic [7:0] LSR_IDLE      = 8'h60;  // TEMT | THRE
   localparam logic [7:0] LSR_DR        = 8'h01;
   localparam logic [7:0] MSR_NO_LOOP   = 8'hB0;  // DCD | DSR | CTS
   localparam logic [7:0] DIV_LOW_9600  = 8'd12;
   localparam logic [7:0] DIV_HIGH_9600 = 8'd0;

   typedef struct packed {
      logic [1:0] action;
      logic [2:0] offset;
      logic [7:0] wdata;
   } req_type;

   typedef struct packed {
      logic [7:0] rdata;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       irq_pulse;
      logic       rx_overflow;
   } rsp_type;

endpackage

>>> hdl/uart_16550_register_file_core.sv
// ----------------------------------------------------------------------------
// uart_16550_register_file_core
// Simplified 16550 register file with a receive FIFO held in a synchronous
// memory; one response transaction for every request transaction.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel (req_valid / req_ready / req_data) carries a bus read, a
//    bus write at offsets 0-7, or a byte received from the serial line.
//  - rsp channel (rsp_valid / rsp_ready / rsp_data) returns exactly one
//    transaction per request: read data, transmitted byte, IRQ pulse and the
//    receive-overflow flag.
//  - The response is registered: it appears in the cycle after the request
//    is accepted. One transaction per cycle while responses are taken; the
//    single response register is refilled in the same cycle it is drained.
//  - Register state updates at the accepting edge, so the next request sees
//    it at once. An RBR read issues its memory read at that same edge; the
//    registered memory output feeds rsp_data.rdata in the next cycle.
//  - When the receiver stalls (rsp_ready low with rsp_valid high), the
//    response and the memory read register hold and req_ready drops until
//    the response is taken.
//  - Reset clears all control registers and empties the receive FIFO at
//    once; the FIFO memory itself is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module uart_16550_register_file_core #(
   parameter int unsigned RX_DEPTH = u16550rf_pkg::RX_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  u16550rf_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output u16550rf_pkg::rsp_type rsp_data
);

   localparam int unsigned PTR_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(RX_DEPTH + 1);

   // Control registers
   logic [7:0]       lcr_ff, lcr_in;
   logic [7:0]       mcr_ff, mcr_in;
   logic [3:0]       ier_ff, ier_in;
   logic [7:0]       fcr_ff, fcr_in;
   logic [7:0]       scr_ff, scr_in;
   logic [7:0]       dll_ff, dll_in;
   logic [7:0]       dlh_ff, dlh_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Response stage
   logic                  rsp_valid_ff, rsp_valid_in;
   u16550rf_pkg::rsp_type rsp_ff, rsp_in;
   logic                  from_mem_ff, from_mem_in;

   // Receive FIFO memory and its registered read port
   logic [7:0] rx_store_ff [RX_DEPTH];
   logic [7:0] rx_rd_ff;

   logic accept;
   logic dlab;
   logic loopback;
   logic has_data;
   logic full;
   logic push;
   logic pop;

   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;

   assign dlab     = lcr_ff[u16550rf_pkg::LCR_DLAB_BIT];
   assign loopback = mcr_ff[u16550rf_pkg::MCR_LOOP_BIT];
   assign has_data = (count_ff != '0);
   assign full     = (count_ff == CNT_W'(RX_DEPTH));

   always_comb begin
      lcr_in       = lcr_ff;
      mcr_in       = mcr_ff;
      ier_in       = ier_ff;
      fcr_in       = fcr_ff;
      scr_in       = scr_ff;
      dll_in       = dll_ff;
      dlh_in       = dlh_ff;
      rsp_in       = '0;
      from_mem_in  = 1'b0;
      push         = 1'b0;
      pop          = 1'b0;

      // Drop the response once taken; load a fresh one on accept
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end

      if (accept) begin
         case (req_data.action)
            u16550rf_pkg::ACT_READ: begin
               case (req_data.offset)
                  u16550rf_pkg::OFF_DATA: begin
                     if (dlab) begin
                        rsp_in.rdata = u16550rf_pkg::DIV_LOW_9600;
                     end else if (has_data) begin
                        // Read data comes from the registered memory output
                        pop         = 1'b1;
                        from_mem_in = 1'b1;
                     end
                  end
                  u16550rf_pkg::OFF_IER: begin
                     rsp_in.rdata = dlab ? u16550rf_pkg::DIV_HIGH_9600 : {4'b0, ier_ff};
                  end
                  u16550rf_pkg::OFF_IIR: begin
                     if (ier_ff[u16550rf_pkg::IER_RX_BIT] && has_data) begin
                        rsp_in.rdata = u16550rf_pkg::IIR_RX;
                     end else if (ier_ff[u16550rf_pkg::IER_TX_BIT]) begin
                        rsp_in.rdata = u16550rf_pkg::IIR_TX;
                     end else begin
                        rsp_in.rdata = u16550rf_pkg::IIR_NONE;
                     end
                     if (fcr_ff[u16550rf_pkg::FCR_EN_BIT]) begin
                        rsp_in.rdata = rsp_in.rdata | u16550rf_pkg::IIR_FIFO;
                     end
                  end
                  u16550rf_pkg::OFF_LCR: rsp_in.rdata = lcr_ff;
                  u16550rf_pkg::OFF_MCR: rsp_in.rdata = mcr_ff;
                  u16550rf_pkg::OFF_LSR: begin
                     rsp_in.rdata = u16550rf_pkg::LSR_IDLE
                                  | (has_data ? u16550rf_pkg::LSR_DR : 8'h00);
                  end
                  u16550rf_pkg::OFF_MSR: begin
                     // Loopback: OUT2->DCD, OUT1->RI, DTR->DSR, RTS->CTS
                     if (loopback) begin
                        rsp_in.rdata = {mcr_ff[u16550rf_pkg::MCR_OUT2_BIT],
                                        mcr_ff[u16550rf_pkg::MCR_OUT1_BIT],
                                        mcr_ff[u16550rf_pkg::MCR_DTR_BIT],
                                        mcr_ff[u16550rf_pkg::MCR_RTS_BIT],
                                        4'b0};
                     end else begin
                        rsp_in.rdata = u16550rf_pkg::MSR_NO_LOOP;
                     end
                  end
                  default: rsp_in.rdata = scr_ff;
               endcase
            end

            u16550rf_pkg::ACT_WRITE: begin
               case (req_data.offset)
                  u16550rf_pkg::OFF_DATA: begin
                     if (dlab) begin
                        dll_in = req_data.wdata;
                     end else if (loopback) begin
                        // THR loops straight back into the receive FIFO
                        if (full) begin
                           rsp_in.rx_overflow = 1'b1;
                        end else begin
                           push = 1'b1;
                        end
                     end else begin
                        rsp_in.tx_valid  = 1'b1;
                        rsp_in.tx_byte   = req_data.wdata;
                        rsp_in.irq_pulse = ier_ff[u16550rf_pkg::IER_TX_BIT];
                     end
                  end
                  u16550rf_pkg::OFF_IER: begin
                     if (dlab) begin
                        dlh_in = req_data.wdata;
                     end else begin
                        ier_in = req_data.wdata[3:0];
                        rsp_in.irq_pulse = req_data.wdata[u16550rf_pkg::IER_TX_BIT]
                           | (req_data.wdata[u16550rf_pkg::IER_RX_BIT] & has_data);
                     end
                  end
                  u16550rf_pkg::OFF_IIR: fcr_in = req_data.wdata;
                  u16550rf_pkg::OFF_LCR: lcr_in = req_data.wdata;
                  u16550rf_pkg::OFF_MCR: mcr_in = req_data.wdata;
                  u16550rf_pkg::OFF_SCR: scr_in = req_data.wdata;
                  default: ;  // LSR and MSR are read-only
               endcase
            end

            u16550rf_pkg::ACT_LINE: begin
               if (full) begin
                  rsp_in.rx_overflow = 1'b1;
               end else begin
                  push             = 1'b1;
                  rsp_in.irq_pulse = ier_ff[u16550rf_pkg::IER_RX_BIT];
               end
            end

            default: ;  // unused action: all outputs stay zero
         endcase
      end

      // FIFO pointers; push and pop never coincide since one transaction
      // carries one action
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in  = (tail_ff == PTR_W'(RX_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end
      if (pop) begin
         head_in  = (head_ff == PTR_W'(RX_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lcr_ff       <= '0;
         mcr_ff       <= '0;
         ier_ff       <= '0;
         fcr_ff       <= '0;
         scr_ff       <= '0;
         dll_ff       <= '0;
         dlh_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lcr_ff       <= lcr_in;
         mcr_ff       <= mcr_in;
         ier_ff       <= ier_in;
         fcr_ff       <= fcr_in;
         scr_ff       <= scr_in;
         dll_ff       <= dll_in;
         dlh_ff       <= dlh_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload of the response stage; hold while stalled
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff      <= rsp_in;
         from_mem_ff <= from_mem_in;
      end
   end

   // Receive FIFO memory. The head entry of a non-empty FIFO was written at
   // an earlier edge, so a pop never reads an entry written in its own cycle.
   always_ff @(posedge clock) begin
      if (push) begin
         rx_store_ff[tail_ff] <= req_data.wdata;
      end
      if (pop) begin
         rx_rd_ff <= rx_store_ff[head_ff];
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      rsp_data = rsp_ff;
      if (from_mem_ff) begin
         rsp_data.rdata = rx_rd_ff;
      end
   end

endmodule

>>> sim/uart_16550_register_file_core_tb.sv
// ----------------------------------------------------------------------------
// uart_16550_register_file_core_tb
// Self-checking bench for the 16550 register file core. Bus reads and writes
// and line bytes go in on the request channel. A scoreboard keeps its own copy
// of the UART registers and the receive FIFO, and from that copy it works out
// the response to each accepted request. Each response is compared field by
// field as it comes out. Both channels idle and stall at random, and there is
// one long receiver hold-off.
// ----------------------------------------------------------------------------
module uart_16550_register_file_core_tb;
   import u16550rf_pkg::*;

   localparam int unsigned FIFO_DEPTH  = RX_DEPTH_DEFAULT;
   localparam int unsigned ITEM_TARGET = 1650;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned HOLD_AFTER  = 300;   // transactions before the long hold-off
   localparam int unsigned HOLD_CYCLES = 80;

   // action code with no meaning: the block must answer with all zeros
   localparam logic [1:0] ACT_SPARE = 2'd3;

   // MSR bits as seen in loopback
   localparam logic [7:0] MSR_CTS = 8'h10;
   localparam logic [7:0] MSR_DSR = 8'h20;
   localparam logic [7:0] MSR_RI  = 8'h40;
   localparam logic [7:0] MSR_DCD = 8'h80;

   typedef enum int {EP_MIX, EP_FILL, EP_DRAIN, EP_SETUP, EP_NOISE} episode_kind;

   // -------------------------------------------------------------------------
   // Scoreboard: shadow register file plus the queue of expected responses
   // -------------------------------------------------------------------------
   class uart_scoreboard;
      logic [7:0]  lcr, mcr, fcr, scr, dll, dlh;
      logic [3:0]  ier;
      logic [7:0]  rx_mem [FIFO_DEPTH];
      int unsigned rx_head, rx_tail, rx_level;
      rsp_type     expected_q[$];
      int unsigned accepted;
      int unsigned errors;

      function new();
         lcr = '0; mcr = '0; fcr = '0; scr = '0; dll = '0; dlh = '0; ier = '0;
         rx_head = 0; rx_tail = 0; rx_level = 0;
         accepted = 0; errors = 0;
      endfunction

      // store a received byte; 0 means it was dropped on a full FIFO
      function bit rx_push(logic [7:0] b);
         if (rx_level >= FIFO_DEPTH) return 1'b0;
         rx_mem[rx_tail] = b;
         rx_tail = (rx_tail + 1) % FIFO_DEPTH;
         rx_level++;
         return 1'b1;
      endfunction

      // work out the response to an accepted request and advance the shadow
      function void note_request(req_type r);
         rsp_type    e;
         logic [7:0] v;
         bit         dlab;
         e    = '0;
         v    = '0;
         dlab = lcr[LCR_DLAB_BIT];
         accepted++;
         case (r.action)
            ACT_READ: begin
               case (r.offset)
                  OFF_DATA: begin
                     if (dlab) begin
                        v = DIV_LOW_9600;
                     end else if (rx_level > 0) begin
                        v = rx_mem[rx_head];
                        rx_head = (rx_head + 1) % FIFO_DEPTH;
                        rx_level--;
                     end
                  end
                  OFF_IER: v = dlab ? DIV_HIGH_9600 : {4'h0, ier};
                  OFF_IIR: begin
                     if (ier[IER_RX_BIT] && rx_level > 0) v = IIR_RX;
                     else if (ier[IER_TX_BIT]) v = IIR_TX;
                     else v = IIR_NONE;
                     if (fcr[FCR_EN_BIT]) v = v | IIR_FIFO;
                  end
                  OFF_LCR: v = lcr;
                  OFF_MCR: v = mcr;
                  OFF_LSR: v = LSR_IDLE | ((rx_level > 0) ? LSR_DR : 8'h00);
                  OFF_MSR: begin
                     if (mcr[MCR_LOOP_BIT]) begin
                        if (mcr[MCR_DTR_BIT])  v = v | MSR_DSR;
                        if (mcr[MCR_RTS_BIT])  v = v | MSR_CTS;
                        if (mcr[MCR_OUT1_BIT]) v = v | MSR_RI;
                        if (mcr[MCR_OUT2_BIT]) v = v | MSR_DCD;
                     end else begin
                        v = MSR_NO_LOOP;
                     end
                  end
                  default: v = scr;
               endcase
               e.rdata = v;
            end
            ACT_WRITE: begin
               case (r.offset)
                  OFF_DATA: begin
                     if (dlab) begin
                        dll = r.wdata;
                     end else if (mcr[MCR_LOOP_BIT]) begin
                        if (!rx_push(r.wdata)) e.rx_overflow = 1'b1;
                     end else begin
                        e.tx_valid  = 1'b1;
                        e.tx_byte   = r.wdata;
                        e.irq_pulse = ier[IER_TX_BIT];
                     end
                  end
                  OFF_IER: begin
                     if (dlab) begin
                        dlh = r.wdata;
                     end else begin
                        ier = r.wdata[3:0];
                        e.irq_pulse = ier[IER_TX_BIT] || (ier[IER_RX_BIT] && rx_level > 0);
                     end
                  end
                  OFF_IIR: fcr = r.wdata;
                  OFF_LCR: lcr = r.wdata;
                  OFF_MCR: mcr = r.wdata;
                  OFF_SCR: scr = r.wdata;
                  default: ;
               endcase
            end
            ACT_LINE: begin
               if (rx_push(r.wdata)) e.irq_pulse = ier[IER_RX_BIT];
               else e.rx_overflow = 1'b1;
            end
            default: ;
         endcase
         expected_q = {expected_q, e};
      endfunction

      function void field_check(string name, logic [7:0] want, logic [7:0] seen);
         if (seen !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
            errors++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: response with nothing outstanding, expected none, actual %h",
                     $time, got);
            errors++;
            return;
         end
         e = expected_q[0];
         expected_q.delete(0);
         field_check("rdata",       e.rdata,       got.rdata);
         field_check("tx_valid",    e.tx_valid,    got.tx_valid);
         field_check("tx_byte",     e.tx_byte,     got.tx_byte);
         field_check("irq_pulse",   e.irq_pulse,   got.irq_pulse);
         field_check("rx_overflow", e.rx_overflow, got.rx_overflow);
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, DUT and run limit
   // -------------------------------------------------------------------------
   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   uart_scoreboard sb;
   int unsigned    cycle_count = 0;
   int unsigned    items_sent  = 0;
   bit             sender_calm = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   uart_16550_register_file_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // drop the run if it stalls well beyond the slowest legal pace
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------

   // Offer one transaction, hold it until accepted, then maybe idle a while.
   // Valid is only lowered when a gap follows, so back-to-back transactions
   // keep it high without a glitch.
   task automatic send_item(req_type item);
      int unsigned roll;
      int unsigned gap;
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_request(item);
      if (item.action != ACT_SPARE) items_sent++;
      roll = $urandom_range(0, 99);
      if (sender_calm || roll < 60) gap = 0;
      else if (roll < 95) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 30);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Random request shaped by the kind of episode. Outside noise, LCR and
   // MCR writes mostly keep DLAB and loopback clear so that the FIFO path
   // stays reachable most of the time.
   function automatic req_type random_item(episode_kind kind);
      req_type r;
      r.action = 2'($urandom_range(0, 2));
      r.offset = 3'($urandom_range(0, 7));
      r.wdata  = 8'($urandom_range(0, 255));
      case (kind)
         EP_FILL: r.action = ACT_LINE;
         EP_DRAIN: begin
            r.action = ACT_READ;
            if ($urandom_range(0, 3) != 0) r.offset = OFF_DATA;
         end
         EP_SETUP: begin
            r.action = ACT_WRITE;
            r.offset = 3'(OFF_IER + $urandom_range(0, 3));
         end
         EP_NOISE: r.action = 2'($urandom_range(0, 3));
         default: ;
      endcase
      if (kind != EP_NOISE && r.action == ACT_WRITE) begin
         if (r.offset == OFF_LCR && $urandom_range(0, 3) != 0) r.wdata[LCR_DLAB_BIT] = 1'b0;
         if (r.offset == OFF_MCR && $urandom_range(0, 2) != 0) r.wdata[MCR_LOOP_BIT] = 1'b0;
      end
      return r;
   endfunction

   initial begin : stimulus
      int unsigned roll;
      int unsigned len;
      episode_kind kind;

      sb = new();
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: idle reads, empty RBR read, IER masking and IRQ
      sender_calm = 1'b1;
      send_item({ACT_READ,  OFF_LSR,  8'h00});
      send_item({ACT_READ,  OFF_DATA, 8'h00});
      send_item({ACT_READ,  OFF_IIR,  8'h00});
      send_item({ACT_READ,  OFF_MSR,  8'h00});
      send_item({ACT_WRITE, OFF_IER,  8'hFF});
      send_item({ACT_READ,  OFF_IER,  8'h00});
      send_item({ACT_WRITE, OFF_IIR,  8'h01});
      send_item({ACT_READ,  OFF_IIR,  8'h00});
      // line byte with receive interrupt on, then IIR/LSR with data pending
      send_item({ACT_LINE,  OFF_DATA, 8'hA5});
      send_item({ACT_READ,  OFF_IIR,  8'h00});
      send_item({ACT_READ,  OFF_LSR,  8'h00});
      send_item({ACT_WRITE, OFF_IER,  8'h01});
      // THR write sent on the line
      send_item({ACT_WRITE, OFF_DATA, 8'h5A});
      // divisor latches: stored but reads stay fixed
      send_item({ACT_WRITE, OFF_LCR,  8'h80});
      send_item({ACT_WRITE, OFF_DATA, 8'hFF});
      send_item({ACT_WRITE, OFF_IER,  8'h00});
      send_item({ACT_READ,  OFF_DATA, 8'h00});
      send_item({ACT_READ,  OFF_IER,  8'h00});
      // writes to LSR and MSR go nowhere
      send_item({ACT_WRITE, OFF_LCR,  8'h7F});
      send_item({ACT_WRITE, OFF_LSR,  8'hFF});
      send_item({ACT_WRITE, OFF_MSR,  8'hFF});
      // loopback: MSR mirrors MCR, THR write lands in the FIFO
      send_item({ACT_WRITE, OFF_MCR,  8'h1F});
      send_item({ACT_READ,  OFF_MSR,  8'h00});
      send_item({ACT_WRITE, OFF_DATA, 8'h00});
      send_item({ACT_READ,  OFF_DATA, 8'h00});
      send_item({ACT_READ,  OFF_DATA, 8'h00});
      // unused action code, scratch at full scale
      send_item({ACT_SPARE, OFF_SCR,  8'hFF});
      send_item({ACT_WRITE, OFF_SCR,  8'hFF});
      send_item({ACT_READ,  OFF_SCR,  8'h00});

      // random episodes: fills and drains walk the FIFO level up to full
      // (overflow) and down to empty; setup writes move IER/FCR/LCR/MCR
      while (items_sent < ITEM_TARGET) begin
         roll = $urandom_range(0, 9);
         if (roll < 3) kind = EP_FILL;
         else if (roll < 5) kind = EP_DRAIN;
         else if (roll < 7) kind = EP_SETUP;
         else if (roll < 9) kind = EP_MIX;
         else kind = EP_NOISE;
         sender_calm = ($urandom_range(0, 3) == 0);
         len = (kind == EP_SETUP) ? $urandom_range(1, 3) : $urandom_range(4, 24);
         repeat (len) send_item(random_item(kind));
      end
      req_valid <= 1'b0;

      // drain the outstanding responses, then allow for the pipeline
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // -------------------------------------------------------------------------
   // Response side: check each accepted transaction, then choose next ready
   // -------------------------------------------------------------------------
   initial begin : response_side
      int unsigned hold;
      int unsigned phase_left;
      int unsigned roll;
      bit          calm;
      bit          held_once;
      hold       = 0;
      phase_left = 0;
      calm       = 1'b1;
      held_once  = 1'b0;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else if (!held_once && sb.accepted >= HOLD_AFTER) begin
            // long hold-off: the sender keeps offering, so the core backs up
            held_once = 1'b1;
            hold      = HOLD_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else begin
            if (phase_left == 0) begin
               calm       = ($urandom_range(0, 2) == 0);
               phase_left = $urandom_range(20, 200);
            end else begin
               phase_left--;
            end
            roll = $urandom_range(0, 99);
            if (calm || roll < 55) begin
               rsp_ready <= 1'b1;
            end else if (roll < 95) begin
               hold = $urandom_range(0, 3);
               rsp_ready <= 1'b0;
            end else begin
               hold = $urandom_range(10, 40);
               rsp_ready <= 1'b0;
            end
         end
         @(posedge clock);
      end
   end

endmodule
